// File: rtl/pth_pkg.sv
`default_nettype none
package pth_pkg;

  localparam int BUCKETS_DEF  = 1024;
  localparam int POOL_DEF     = 1024;

  localparam int KEY_W        = 64;
  localparam int SIZE_W       = 32;
  localparam int LINE_W       = 16;
  localparam int CNT_W        = 11;

  localparam int          MIX_SHIFT = 16;
  localparam logic [26:0] MIX_MULT  = 27'h45d9f3b;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_LO0,
    S_HI0,
    S_SUM0,
    S_LO1,
    S_HI1,
    S_SUM1,
    S_HEAD_RD,
    S_HEAD_LD,
    S_WALK,
    S_CMP,
    S_ACT,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLR,
    DP_LOAD,
    DP_MUL_LO,
    DP_MUL_HI,
    DP_MUL_SUM,
    DP_HEAD_LD,
    DP_NEXT,
    DP_HIT,
    DP_ACT,
    DP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic skip;
    logic cur_zero;
    logic key_eq;
    logic slot_free;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/pth_ram.sv
`default_nettype none
module pth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/pth_ctrl.sv
`default_nettype none
module pth_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output pth_pkg::cmd_t      cmd,
  input  wire pth_pkg::sts_t sts
);
  import pth_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    in_ready   = 1'b0;
    unique case (state)
      S_CLR: begin
        cmd.op = DP_CLR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_LO0;
        end
      end
      S_LO0: begin
        if (sts.skip) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = DP_MUL_LO;
          state_next = S_HI0;
        end
      end
      S_HI0: begin
        cmd.op     = DP_MUL_HI;
        state_next = S_SUM0;
      end
      S_SUM0: begin
        cmd.op     = DP_MUL_SUM;
        state_next = S_LO1;
      end
      S_LO1: begin
        cmd.op     = DP_MUL_LO;
        state_next = S_HI1;
      end
      S_HI1: begin
        cmd.op     = DP_MUL_HI;
        state_next = S_SUM1;
      end
      S_SUM1: begin
        cmd.op     = DP_MUL_SUM;
        state_next = S_HEAD_RD;
      end
      S_HEAD_RD: state_next = S_HEAD_LD;
      S_HEAD_LD: begin
        cmd.op     = DP_HEAD_LD;
        state_next = S_WALK;
      end
      S_WALK: begin
        // node read is addressed from cur every cycle
        if (sts.cur_zero) state_next = S_ACT;
        else              state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.key_eq) begin
          cmd.op     = DP_HIT;
          state_next = S_ACT;
        end else begin
          cmd.op     = DP_NEXT;
          state_next = S_WALK;
        end
      end
      S_ACT: begin
        cmd.op     = DP_ACT;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.slot_free) begin
          cmd.op     = DP_RESP;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/pth_datapath.sv
`default_nettype none
module pth_datapath #(
  parameter int BUCKETS      = pth_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = pth_pkg::POOL_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pth_pkg::cmd_t               cmd,
  output pth_pkg::sts_t                    sts,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_wr_data,
  input  wire logic [1:0]                  op,
  input  wire logic [pth_pkg::KEY_W-1:0]   key,
  input  wire logic [pth_pkg::SIZE_W-1:0]  entry_size,
  input  wire logic [pth_pkg::LINE_W-1:0]  source_line,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       status,
  output logic                             found,
  output logic [pth_pkg::SIZE_W-1:0]       found_size,
  output logic [pth_pkg::LINE_W-1:0]       found_line,
  output logic [pth_pkg::CNT_W-1:0]        live_count
);
  import pth_pkg::*;

  localparam int PTR_W = $clog2(POOL_ENTRIES + 1);
  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int BKT_W = $clog2(BUCKETS);

  logic              tracking_enabled;
  logic [1:0]        op_q;
  logic [KEY_W-1:0]  key_q, x, acc;
  logic [SIZE_W-1:0] size_q, hit_size;
  logic [LINE_W-1:0] line_q, hit_line;
  logic [58:0]       prod;
  logic [PTR_W-1:0]  cur, prev, head_sv, link_sv;
  logic [PTR_W-1:0]  fresh, sp, live;
  logic [BKT_W-1:0]  clr_cnt;
  logic              hit;

  status_t           res_status;
  logic              res_found;
  logic [SIZE_W-1:0] res_size;
  logic [LINE_W-1:0] res_line;
  status_t           out_status;

  logic [KEY_W-1:0]  y;
  logic [31:0]       mul_in;
  logic [58:0]       mul_out;
  logic [BKT_W-1:0]  bucket;

  logic [PTR_W-1:0]  head_q, link_q;
  logic [KEY_W-1:0]  key_rq;
  logic [SIZE_W-1:0] size_rq;
  logic [LINE_W-1:0] line_rq;
  logic [IDX_W-1:0]  stack_q;

  logic [IDX_W-1:0]  cur_idx, alloc_idx, size_waddr, link_waddr, stack_raddr;
  logic [BKT_W-1:0]  head_waddr;
  logic [PTR_W-1:0]  head_wdata, link_wdata;
  logic              head_we, size_we, link_we;
  logic              act, op_add, op_rem, op_look;
  logic              pool_empty, use_fresh, do_alloc, do_update, do_unlink;

  // mix: x ^= x >> 16, then x *= MIX_MULT as two 32-bit halves
  assign y       = x ^ (x >> MIX_SHIFT);
  assign mul_in  = (cmd.op == DP_MUL_HI) ? y[63:32] : y[31:0];
  assign mul_out = {27'b0, mul_in} * {32'b0, MIX_MULT};
  assign bucket  = y[BKT_W-1:0];

  assign cur_idx     = IDX_W'(cur - PTR_W'(1));
  assign stack_raddr = IDX_W'(sp - PTR_W'(1));

  assign act     = (cmd.op == DP_ACT);
  assign op_add  = (op_q == OP_ADD);
  assign op_rem  = (op_q == OP_REMOVE);
  assign op_look = (op_q == OP_LOOKUP);

  // nodes never handed out come from a fill counter, recycled ones from the stack
  assign use_fresh  = (fresh != PTR_W'(POOL_ENTRIES));
  assign pool_empty = !use_fresh && (sp == '0);
  assign alloc_idx  = use_fresh ? fresh[IDX_W-1:0] : stack_q;

  assign do_alloc  = act && op_add && !hit && !pool_empty;
  assign do_update = act && op_add && hit;
  assign do_unlink = act && op_rem && hit;

  always_comb begin
    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = '0;
    if (cmd.op == DP_CLR) begin
      head_we    = 1'b1;
      head_waddr = clr_cnt;
    end else if (do_alloc) begin
      head_we    = 1'b1;
      head_wdata = PTR_W'(alloc_idx) + PTR_W'(1);
    end else if (do_unlink && prev == '0) begin
      head_we    = 1'b1;
      head_wdata = link_sv;
    end
  end

  assign size_we    = do_alloc || do_update;
  assign size_waddr = do_alloc ? alloc_idx : cur_idx;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = alloc_idx;
    link_wdata = head_sv;
    if (do_alloc) begin
      link_we = 1'b1;
    end else if (do_unlink && prev != '0) begin
      link_we    = 1'b1;
      link_waddr = IDX_W'(prev - PTR_W'(1));
      link_wdata = link_sv;
    end
  end

  pth_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_head (
    .clk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(bucket), .rdata(head_q)
  );

  pth_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_key (
    .clk, .we(do_alloc), .waddr(alloc_idx), .wdata(key_q),
    .raddr(cur_idx), .rdata(key_rq)
  );

  pth_ram #(.WIDTH(SIZE_W), .DEPTH(POOL_ENTRIES)) u_size (
    .clk, .we(size_we), .waddr(size_waddr), .wdata(size_q),
    .raddr(cur_idx), .rdata(size_rq)
  );

  pth_ram #(.WIDTH(LINE_W), .DEPTH(POOL_ENTRIES)) u_line (
    .clk, .we(size_we), .waddr(size_waddr), .wdata(line_q),
    .raddr(cur_idx), .rdata(line_rq)
  );

  pth_ram #(.WIDTH(PTR_W), .DEPTH(POOL_ENTRIES)) u_link (
    .clk, .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(cur_idx), .rdata(link_q)
  );

  // sp is stable long before an allocation, so stack_q already holds the top
  pth_ram #(.WIDTH(IDX_W), .DEPTH(POOL_ENTRIES)) u_stack (
    .clk, .we(do_unlink), .waddr(sp[IDX_W-1:0]), .wdata(cur_idx),
    .raddr(stack_raddr), .rdata(stack_q)
  );

  always_comb begin
    sts.clr_last  = (clr_cnt == BKT_W'(BUCKETS - 1));
    sts.skip      = (key_q == '0) || !(op_add || op_rem || op_look) ||
                    (op_add && !tracking_enabled);
    sts.cur_zero  = (cur == '0);
    sts.key_eq    = (key_rq == key_q);
    sts.slot_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enabled <= 1'b0;
      fresh            <= '0;
      sp               <= '0;
      live             <= '0;
      clr_cnt          <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_wr_en) tracking_enabled <= cfg_wr_data;
      if (cmd.op == DP_RESP) out_valid <= 1'b1;
      else if (out_ready)    out_valid <= 1'b0;
      unique case (cmd.op)
        DP_CLR: clr_cnt <= clr_cnt + BKT_W'(1);
        DP_ACT: begin
          if (do_alloc) begin
            live <= live + PTR_W'(1);
            if (use_fresh) fresh <= fresh + PTR_W'(1);
            else           sp    <= sp - PTR_W'(1);
          end
          if (do_unlink) begin
            live <= live - PTR_W'(1);
            sp   <= sp + PTR_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        op_q       <= op;
        key_q      <= key;
        x          <= key;
        size_q     <= entry_size;
        line_q     <= source_line;
        hit        <= 1'b0;
        res_status <= ST_IGNORED;
        res_found  <= 1'b0;
        res_size   <= '0;
        res_line   <= '0;
      end
      DP_MUL_LO: prod <= mul_out;
      DP_MUL_HI: begin
        acc  <= {5'b0, prod};
        prod <= mul_out;
      end
      DP_MUL_SUM: x <= acc + {prod[31:0], 32'b0};
      DP_HEAD_LD: begin
        cur     <= head_q;
        head_sv <= head_q;
        prev    <= '0;
      end
      DP_NEXT: begin
        prev <= cur;
        cur  <= link_q;
      end
      DP_HIT: begin
        hit      <= 1'b1;
        link_sv  <= link_q;
        hit_size <= size_rq;
        hit_line <= line_rq;
      end
      DP_ACT: begin
        res_found <= hit;
        if (op_add) begin
          if (hit)             res_status <= ST_DONE;
          else if (pool_empty) res_status <= ST_FULL;
          else                 res_status <= ST_DONE;
        end else begin
          res_status <= hit ? ST_DONE : ST_NOT_FOUND;
          if (op_look && hit) begin
            res_size <= hit_size;
            res_line <= hit_line;
          end
        end
      end
      DP_RESP: begin
        out_status <= res_status;
        found      <= res_found;
        found_size <= res_size;
        found_line <= res_line;
        live_count <= CNT_W'(live);
      end
      default: ;
    endcase
  end

  assign status = out_status;

endmodule
`default_nettype wire

// File: rtl/pointer_tracking_hash_table.sv
`default_nettype none
// Chained hash set of live 64-bit pointer keys, each holding a size and a source
// line. One request is taken at a time; it returns one word. A request runs two
// mix rounds, each a low-half multiply, a high-half multiply and a sum on one
// shared 32x27 multiplier, then a bucket head read, then a chain walk that reads
// each node through the node memories' registered read port and compares its
// key. Null keys, op code 3 and adds while tracking is off skip the mix and the
// walk. After reset the bucket heads are cleared one per cycle, and in_ready
// stays low until the BUCKETS heads (1024 by default) are clear; tracking_enabled
// may be written anytime the block is idle. BUCKETS must be a power of two.
module pointer_tracking_hash_table #(
  parameter int BUCKETS      = pth_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = pth_pkg::POOL_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  op,
  input  wire logic [pth_pkg::KEY_W-1:0]   key,
  input  wire logic [pth_pkg::SIZE_W-1:0]  entry_size,
  input  wire logic [pth_pkg::LINE_W-1:0]  source_line,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       status,
  output logic                             found,
  output logic [pth_pkg::SIZE_W-1:0]       found_size,
  output logic [pth_pkg::LINE_W-1:0]       found_line,
  output logic [pth_pkg::CNT_W-1:0]        live_count
);
  import pth_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pth_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .cmd, .sts
  );

  pth_datapath #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_dp (
    .clk, .rst, .cmd, .sts, .cfg_wr_en, .cfg_wr_data,
    .op, .key, .entry_size, .source_line,
    .out_valid, .out_ready, .status, .found, .found_size, .found_line, .live_count
  );

endmodule
`default_nettype wire
